// File: rtl/mtq_pkg.sv
// Shared types, widths and arithmetic helpers for the matrix to quaternion block.
// No dependencies; every file that uses it refers to this package by scoped names.
package mtq_pkg;

  localparam int unsigned DataW  = 16;              // Q2.14 sample width
  localparam int unsigned FracW  = 14;              // fraction bits
  localparam int unsigned RadSW  = DataW + 3;       // signed radicand before clamp
  localparam int unsigned RadW   = DataW + 1;       // clamped radicand
  localparam int unsigned NumW   = 2 * DataW;       // root operand, radicand << FracW
  localparam int unsigned RootW  = NumW / 2;        // root bits, one per stage
  localparam int unsigned RemSqW = RootW + 3;       // root remainder
  localparam int unsigned DiffW  = DataW + 1;       // sum or difference of two elements
  localparam int unsigned QuotW  = FracW + 2;       // quotient bits, one per stage
  localparam int unsigned RemDvW = DiffW + 1;       // divider remainder
  localparam int unsigned Lanes  = 4;               // w, x, y, z

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_e;

  // One classified matrix: radicand, four scaled numerators (main slot unused).
  typedef struct packed {
    case_e                       cs;
    logic [RadW-1:0]             rad;
    logic [Lanes-1:0][DiffW-1:0] num;
  } item_t;

  typedef struct packed {
    logic signed [DataW-1:0] w;
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
    case_e                   cs;
  } result_t;

  // Clamp a sign and magnitude to the signed DataW range.
  function automatic logic [DataW-1:0] sat_mag(input logic neg, input logic [DataW:0] mag);
    logic [DataW:0] lim;
    logic [DataW:0] m;
    begin
      lim = neg ? (DataW+1)'(1) << (DataW - 1) : ((DataW+1)'(1) << (DataW - 1)) - 1'b1;
      m   = (mag > lim) ? lim : mag;
      sat_mag = neg ? DataW'((DataW+1)'(0) - m) : DataW'(m);
    end
  endfunction

endpackage

// File: rtl/mtq_in_if.sv
// Input channel: one 3x3 matrix per beat with valid/ready handshake.
// Depends on mtq_pkg for the sample width.
interface mtq_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [mtq_pkg::DataW-1:0] row0_col0;
  logic signed [mtq_pkg::DataW-1:0] row0_col1;
  logic signed [mtq_pkg::DataW-1:0] row0_col2;
  logic signed [mtq_pkg::DataW-1:0] row1_col0;
  logic signed [mtq_pkg::DataW-1:0] row1_col1;
  logic signed [mtq_pkg::DataW-1:0] row1_col2;
  logic signed [mtq_pkg::DataW-1:0] row2_col0;
  logic signed [mtq_pkg::DataW-1:0] row2_col1;
  logic signed [mtq_pkg::DataW-1:0] row2_col2;

  modport source (output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                  row1_col2, row2_col0, row2_col1, row2_col2, input ready);
  modport sink   (input valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                  row1_col2, row2_col0, row2_col1, row2_col2, output ready);
endinterface

// File: rtl/mtq_out_if.sv
// Output channel: one quaternion and its case code per beat, valid/ready handshake.
// Depends on mtq_pkg for the sample width.
interface mtq_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [mtq_pkg::DataW-1:0] quat_w;
  logic signed [mtq_pkg::DataW-1:0] quat_x;
  logic signed [mtq_pkg::DataW-1:0] quat_y;
  logic signed [mtq_pkg::DataW-1:0] quat_z;
  logic [1:0]                      case_taken;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, case_taken, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, case_taken, output ready);
endinterface

// File: rtl/mtq_front.sv
// Front end: picks the Shepperd case, forms radicand and numerators, and queues
// the result in a two-entry register queue. Depends on mtq_pkg and mtq_in_if.
module mtq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  mtq_in_if.sink          in_i,
  input  logic            pop_i,
  output logic            item_valid_o,
  output mtq_pkg::item_t  item_o
);

  logic signed [mtq_pkg::DataW-1:0] m [3][3];
  logic signed [mtq_pkg::RadSW-1:0] trace;
  logic signed [mtq_pkg::RadSW-1:0] rad_s;
  logic signed [mtq_pkg::RadSW-1:0] one;
  mtq_pkg::item_t                   cls;
  logic [1:0]                       ii, jj, kk;
  mtq_pkg::item_t                   queue_q [2];
  logic                             wr_ptr_q, rd_ptr_q;
  logic [1:0]                       count_q;
  logic                             push, pop;

  assign m[0][0] = in_i.row0_col0;
  assign m[0][1] = in_i.row0_col1;
  assign m[0][2] = in_i.row0_col2;
  assign m[1][0] = in_i.row1_col0;
  assign m[1][1] = in_i.row1_col1;
  assign m[1][2] = in_i.row1_col2;
  assign m[2][0] = in_i.row2_col0;
  assign m[2][1] = in_i.row2_col1;
  assign m[2][2] = in_i.row2_col2;

  assign one   = mtq_pkg::RadSW'(1) <<< mtq_pkg::FracW;
  assign trace = mtq_pkg::RadSW'(m[0][0]) + mtq_pkg::RadSW'(m[1][1])
               + mtq_pkg::RadSW'(m[2][2]);

  always_comb begin
    cls = '0;
    ii  = 2'd0;
    jj  = 2'd1;
    kk  = 2'd2;
    if (trace > 0) begin
      cls.cs     = mtq_pkg::CASE_TRACE;
      rad_s      = trace + one;
      cls.num[1] = mtq_pkg::DiffW'(m[2][1]) - mtq_pkg::DiffW'(m[1][2]);
      cls.num[2] = mtq_pkg::DiffW'(m[0][2]) - mtq_pkg::DiffW'(m[2][0]);
      cls.num[3] = mtq_pkg::DiffW'(m[1][0]) - mtq_pkg::DiffW'(m[0][1]);
    end else begin
      // ties keep the lower axis
      if (m[1][1] > m[0][0]) ii = 2'd1;
      if (m[2][2] > m[ii][ii]) ii = 2'd2;
      unique case (ii)
        2'd0:    begin jj = 2'd1; kk = 2'd2; cls.cs = mtq_pkg::CASE_X; end
        2'd1:    begin jj = 2'd2; kk = 2'd0; cls.cs = mtq_pkg::CASE_Y; end
        default: begin jj = 2'd0; kk = 2'd1; cls.cs = mtq_pkg::CASE_Z; end
      endcase
      rad_s = mtq_pkg::RadSW'(m[ii][ii]) - mtq_pkg::RadSW'(m[jj][jj])
            - mtq_pkg::RadSW'(m[kk][kk]) + one;
      cls.num[0]         = mtq_pkg::DiffW'(m[kk][jj]) - mtq_pkg::DiffW'(m[jj][kk]);
      cls.num[jj + 2'd1] = mtq_pkg::DiffW'(m[jj][ii]) + mtq_pkg::DiffW'(m[ii][jj]);
      cls.num[kk + 2'd1] = mtq_pkg::DiffW'(m[kk][ii]) + mtq_pkg::DiffW'(m[ii][kk]);
    end
    // clamp a negative radicand to zero
    cls.rad = (rad_s > 0) ? mtq_pkg::RadW'(rad_s) : '0;
  end

  assign in_i.ready   = (count_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign pop          = pop_i && (count_q != 2'd0);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= cls;
  end

endmodule

// File: rtl/mtq_back.sv
// Back end: pipelined digit-by-digit square root, then four pipelined restoring
// dividers and a saturating output register. Depends on mtq_pkg.
module mtq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  mtq_pkg::item_t    item_i,
  output logic              pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output mtq_pkg::result_t  res_o
);

  typedef struct packed {
    mtq_pkg::case_e                                cs;
    logic [mtq_pkg::NumW-1:0]                      n;
    logic [mtq_pkg::RootW-1:0]                     root;
    logic [mtq_pkg::RemSqW-1:0]                    rem;
    logic [mtq_pkg::Lanes-1:0][mtq_pkg::DiffW-1:0] num;
  } sq_t;

  typedef struct packed {
    logic                       neg;
    logic                       ovf;
    logic [mtq_pkg::RemDvW-1:0] rem;
    logic [mtq_pkg::QuotW-1:0]  q;
    logic [mtq_pkg::QuotW-1:0]  nl;
  } lane_t;

  typedef struct packed {
    mtq_pkg::case_e                         cs;
    logic [mtq_pkg::RootW-1:0]              root;
    logic [mtq_pkg::DiffW-1:0]              dd;
    lane_t [mtq_pkg::Lanes-1:0]             ln;
  } dv_t;

  sq_t              sq_q [mtq_pkg::RootW+1];
  sq_t              sq_d [mtq_pkg::RootW+1];
  dv_t              dv_q [mtq_pkg::QuotW+1];
  dv_t              dv_d [mtq_pkg::QuotW+1];
  logic             sq_vld_q [mtq_pkg::RootW+1];
  logic             dv_vld_q [mtq_pkg::QuotW+1];
  logic             en;
  logic             out_vld_q;
  mtq_pkg::result_t out_q, out_d;

  // advance everything when the output register is free or being drained
  assign en          = !out_vld_q || res_ready_i;
  assign pop_o       = en;
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  always_comb begin
    logic [mtq_pkg::RemSqW-1:0] sh, trial;
    logic                       ge;
    sq_d[0]      = '0;
    sq_d[0].cs   = item_i.cs;
    sq_d[0].n    = mtq_pkg::NumW'({item_i.rad, mtq_pkg::FracW'(0)});
    sq_d[0].num  = item_i.num;
    for (int s = 0; s < mtq_pkg::RootW; s++) begin
      sh    = {sq_q[s].rem[mtq_pkg::RemSqW-3:0], sq_q[s].n[mtq_pkg::NumW-1 -: 2]};
      trial = mtq_pkg::RemSqW'({sq_q[s].root, 2'b01});
      ge    = (sh >= trial);
      sq_d[s+1]      = sq_q[s];
      sq_d[s+1].rem  = ge ? sh - trial : sh;
      sq_d[s+1].root = {sq_q[s].root[mtq_pkg::RootW-2:0], ge};
      sq_d[s+1].n    = sq_q[s].n << 2;
    end
  end

  always_comb begin
    logic [mtq_pkg::DiffW-1:0]  a;
    logic [mtq_pkg::RemDvW-1:0] dsh;
    logic                       ge;
    sq_t                        last;
    last           = sq_q[mtq_pkg::RootW];
    dv_d[0]        = '0;
    dv_d[0].cs     = last.cs;
    dv_d[0].root   = last.root;
    dv_d[0].dd     = {last.root, 1'b0};
    for (int l = 0; l < mtq_pkg::Lanes; l++) begin
      dv_d[0].ln[l].neg = last.num[l][mtq_pkg::DiffW-1];
      a = last.num[l][mtq_pkg::DiffW-1] ? mtq_pkg::DiffW'(0) - last.num[l] : last.num[l];
      // quotient reaches 2^QuotW exactly when a >= 4 * (2 * root)
      dv_d[0].ln[l].ovf = ({2'b00, a} >= {last.root, 3'b000});
      dv_d[0].ln[l].rem = mtq_pkg::RemDvW'(a >> 2);
      dv_d[0].ln[l].nl  = mtq_pkg::QuotW'({a[1:0], mtq_pkg::FracW'(0)});
    end
    for (int s = 0; s < mtq_pkg::QuotW; s++) begin
      dv_d[s+1] = dv_q[s];
      for (int l = 0; l < mtq_pkg::Lanes; l++) begin
        dsh = {dv_q[s].ln[l].rem[mtq_pkg::RemDvW-2:0], dv_q[s].ln[l].nl[mtq_pkg::QuotW-1]};
        ge  = (dsh >= mtq_pkg::RemDvW'(dv_q[s].dd));
        dv_d[s+1].ln[l].rem = ge ? dsh - mtq_pkg::RemDvW'(dv_q[s].dd) : dsh;
        dv_d[s+1].ln[l].q   = {dv_q[s].ln[l].q[mtq_pkg::QuotW-2:0], ge};
        dv_d[s+1].ln[l].nl  = dv_q[s].ln[l].nl << 1;
      end
    end
  end

  always_comb begin
    logic [mtq_pkg::Lanes-1:0][mtq_pkg::DataW-1:0] v;
    dv_t                                           f;
    f = dv_q[mtq_pkg::QuotW];
    for (int l = 0; l < mtq_pkg::Lanes; l++) begin
      if (l == int'(f.cs))
        v[l] = mtq_pkg::sat_mag(1'b0, (mtq_pkg::DataW+1)'(f.root >> 1));
      else if (f.root == '0)
        v[l] = '0;
      else if (f.ln[l].ovf)
        v[l] = mtq_pkg::sat_mag(f.ln[l].neg, (mtq_pkg::DataW+1)'(1) << mtq_pkg::DataW);
      else
        v[l] = mtq_pkg::sat_mag(f.ln[l].neg, (mtq_pkg::DataW+1)'(f.ln[l].q));
    end
    out_d.w  = v[0];
    out_d.x  = v[1];
    out_d.y  = v[2];
    out_d.z  = v[3];
    out_d.cs = f.cs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= mtq_pkg::RootW; s++) sq_vld_q[s] <= 1'b0;
      for (int s = 0; s <= mtq_pkg::QuotW; s++) dv_vld_q[s] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      sq_vld_q[0] <= item_valid_i;
      for (int s = 0; s < mtq_pkg::RootW; s++) sq_vld_q[s+1] <= sq_vld_q[s];
      dv_vld_q[0] <= sq_vld_q[mtq_pkg::RootW];
      for (int s = 0; s < mtq_pkg::QuotW; s++) dv_vld_q[s+1] <= dv_vld_q[s];
      out_vld_q <= dv_vld_q[mtq_pkg::QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s <= mtq_pkg::RootW; s++) sq_q[s] <= sq_d[s];
      for (int s = 0; s <= mtq_pkg::QuotW; s++) dv_q[s] <= dv_d[s];
      if (dv_vld_q[mtq_pkg::QuotW]) out_q <= out_d;
    end
  end

endmodule

// File: rtl/matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
// Depends on mtq_pkg, mtq_in_if, mtq_out_if, mtq_front and mtq_back.
//
// Usage:
//   in_i  : one beat carries a 3x3 rotation matrix, nine signed Q2.14 elements.
//   out_o : one beat carries the quaternion w, x, y, z (signed Q2.14, saturated)
//           and case_taken (0 positive trace, 1/2/3 largest diagonal x/y/z).
//   Every input beat yields exactly one output beat, in order.
// Throughput: one matrix per cycle, sustained, as long as out_o is drained.
// Path: from input beat to output valid an item passes the front queue, the
//   square root pipeline (one root bit per stage), the divider pipeline (one
//   quotient bit per stage) and the output register.
// Stalls: while out_o holds a beat that is not taken, the whole back pipeline
//   holds; the two-entry front queue keeps in_i.ready high until it fills.
// Reset: rst_ni clears all valid flags and the queue; no item survives it and
//   in_i.ready is high both while reset is held and after it is released.
module matrix_to_quaternion (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtq_in_if.sink    in_i,
  mtq_out_if.source out_o
);

  logic              item_valid;
  logic              pop;
  mtq_pkg::item_t    item;
  mtq_pkg::result_t  res;

  // front: classify and queue
  mtq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // back: root, divide, saturate, hold result
  mtq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .res_o        (res)
  );

  assign out_o.quat_w     = res.w;
  assign out_o.quat_x     = res.x;
  assign out_o.quat_y     = res.y;
  assign out_o.quat_z     = res.z;
  assign out_o.case_taken = res.cs;

endmodule

// File: tb/mtq_tb_if.sv
// Testbench-side handle on the matrix and quaternion channels.
// Depends on mtq_pkg, mtq_in_if and mtq_out_if from the RTL; this file only groups them.
module mtq_tb_chan (
  mtq_in_if  in_ch,
  mtq_out_if out_ch
);
endmodule

// File: tb/matrix_to_quaternion_tb.sv
// Self-checking bench for matrix_to_quaternion: drives 3x3 Q2.14 matrices,
// predicts each quaternion by Shepperd's method, and compares beats in order.
// Depends on mtq_pkg, mtq_in_if, mtq_out_if and the RTL top level.
module matrix_to_quaternion_tb;

  typedef logic signed [mtq_pkg::DataW-1:0] elem_t;
  typedef elem_t mat_t [3][3];

  typedef struct {
    elem_t w, x, y, z;
    mtq_pkg::case_e cs;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_cnt = 0;
  int   err_cnt = 0;
  bit   quiet_stretch = 1'b0;   // suppress idling on both sides
  quat_t quat_q[$];

  mtq_in_if  in_ch();
  mtq_out_if out_ch();

  mtq_tb_chan u_chan (
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  matrix_to_quaternion uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Generous limit: ~700 beats with idling on both sides, plus pipeline latency.
  localparam int CycleLimit = 200000;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Integer square root of a nonnegative 64-bit value, bit by bit.
  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned op, res, b;
    begin
      op = n; res = 0; b = 64'd1 << 62;
      while (b > op) b = b >> 2;
      while (b != 0) begin
        if (op >= res + b) begin
          op  = op - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    end
  endfunction

  function automatic elem_t clamp_q(input bit neg, input longint unsigned mag);
    longint unsigned lim;
    begin
      lim = neg ? (64'd1 << (mtq_pkg::DataW - 1)) : (64'd1 << (mtq_pkg::DataW - 1)) - 1;
      if (mag > lim) mag = lim;
      return neg ? elem_t'(-longint'(mag)) : elem_t'(mag);
    end
  endfunction

  function automatic longint unsigned root_of(input longint t);
    begin
      if (t <= 0) return 0;
      return isqrt(longint'(t) << mtq_pkg::FracW);
    end
  endfunction

  // diff / (2*root) as a fixed-point fraction, truncated toward zero.
  function automatic elem_t scaled_part(input longint diff, input longint unsigned root);
    bit neg;
    longint unsigned a, d, qi, rem, frac;
    begin
      if (root == 0) return '0;
      neg  = diff < 0;
      a    = neg ? -diff : diff;
      d    = root << 1;
      qi   = a / d;
      rem  = a % d;
      frac = 0;
      if (qi >= (64'd1 << mtq_pkg::DataW)) return clamp_q(neg, 64'd1 << mtq_pkg::DataW);
      for (int b = 0; b < mtq_pkg::FracW; b++) begin
        rem  = rem << 1;
        frac = frac << 1;
        if (rem >= d) begin
          rem  = rem - d;
          frac = frac | 1;
        end
      end
      return clamp_q(neg, (qi << mtq_pkg::FracW) | frac);
    end
  endfunction

  function automatic quat_t predict_quat(input mat_t m);
    quat_t q;
    longint mv [3][3];
    longint one, trace;
    longint unsigned root;
    int i, j, k;
    elem_t part [3];
    begin
      one = longint'(1) << mtq_pkg::FracW;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) mv[r][c] = m[r][c];
      trace = mv[0][0] + mv[1][1] + mv[2][2];
      if (trace > 0) begin
        root = root_of(trace + one);
        q.w  = clamp_q(1'b0, root >> 1);
        q.x  = scaled_part(mv[2][1] - mv[1][2], root);
        q.y  = scaled_part(mv[0][2] - mv[2][0], root);
        q.z  = scaled_part(mv[1][0] - mv[0][1], root);
        q.cs = mtq_pkg::CASE_TRACE;
      end else begin
        // Largest diagonal picks the axis; ties keep the lower index.
        i = 0;
        if (mv[1][1] > mv[0][0]) i = 1;
        if (mv[2][2] > mv[i][i]) i = 2;
        j = (i + 1) % 3;
        k = (j + 1) % 3;
        root    = root_of(mv[i][i] - mv[j][j] - mv[k][k] + one);
        part[i] = clamp_q(1'b0, root >> 1);
        part[j] = scaled_part(mv[j][i] + mv[i][j], root);
        part[k] = scaled_part(mv[k][i] + mv[i][k], root);
        q.w  = scaled_part(mv[k][j] - mv[j][k], root);
        q.x  = part[0];
        q.y  = part[1];
        q.z  = part[2];
        q.cs = (i == 0) ? mtq_pkg::CASE_X : (i == 1) ? mtq_pkg::CASE_Y : mtq_pkg::CASE_Z;
      end
      return q;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one matrix per beat, changed at the falling edge
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    {in_ch.row0_col0, in_ch.row0_col1, in_ch.row0_col2} = '0;
    {in_ch.row1_col0, in_ch.row1_col1, in_ch.row1_col2} = '0;
    {in_ch.row2_col0, in_ch.row2_col1, in_ch.row2_col2} = '0;
    out_ch.ready = 1'b0;
  end

  task automatic send_matrix(input mat_t m);
    // Random gap before the beat, unless in a quiet stretch.
    while (!quiet_stretch && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.row0_col0 <= m[0][0]; in_ch.row0_col1 <= m[0][1]; in_ch.row0_col2 <= m[0][2];
    in_ch.row1_col0 <= m[1][0]; in_ch.row1_col1 <= m[1][1]; in_ch.row1_col2 <= m[1][2];
    in_ch.row2_col0 <= m[2][0]; in_ch.row2_col1 <= m[2][1]; in_ch.row2_col2 <= m[2][2];
    in_ch.valid <= 1'b1;
    // Hold until the beat is taken; record the expectation at that edge.
    do @(posedge clk_i); while (!in_ch.ready);
    quat_q.push_back(predict_quat(m));
    @(negedge clk_i);
  endtask

  // Valid stays high after a beat so the next call can follow without a gap;
  // a gap or wait_drained drops it.

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= quiet_stretch || ($urandom_range(99) >= 21);
  end

  always @(posedge clk_i) begin
    quat_t exp_q;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (quat_q.size() == 0) begin
        $error("quaternion beat with nothing expected");
        err_cnt++;
      end else begin
        exp_q = quat_q.pop_front();
        if (out_ch.quat_w !== exp_q.w) begin
          $error("quat_w expected %0d got %0d", exp_q.w, out_ch.quat_w); err_cnt++;
        end
        if (out_ch.quat_x !== exp_q.x) begin
          $error("quat_x expected %0d got %0d", exp_q.x, out_ch.quat_x); err_cnt++;
        end
        if (out_ch.quat_y !== exp_q.y) begin
          $error("quat_y expected %0d got %0d", exp_q.y, out_ch.quat_y); err_cnt++;
        end
        if (out_ch.quat_z !== exp_q.z) begin
          $error("quat_z expected %0d got %0d", exp_q.z, out_ch.quat_z); err_cnt++;
        end
        if (out_ch.case_taken !== exp_q.cs) begin
          $error("case_taken expected %0d got %0d", exp_q.cs, out_ch.case_taken);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic elem_t rand_elem();
    return elem_t'($urandom);
  endfunction

  // Element near a target value, small jitter.
  function automatic elem_t near(input int v, input int jit);
    int r;
    r = v + $urandom_range(2 * jit) - jit;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return elem_t'(r);
  endfunction

  // Rotation-like matrix: one of four shapes; three lead to the x, y or z case and
  // the first to a positive trace or the x case, with noisy off-diagonals.
  function automatic mat_t rotation_like();
    mat_t m;
    int c, s, shape;
    begin
      c = $urandom_range(16384) - 8192;
      s = $urandom_range(16384) - 8192;
      shape = $urandom_range(3);
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) m[r][k] = near(0, 3000);
      case (shape)
        0: begin
          m[0][0] = near(14000, 2000); m[1][1] = near(c, 3000); m[2][2] = near(c, 3000);
          m[1][2] = near(-s, 500);     m[2][1] = near(s, 500);
        end
        1: begin
          m[0][0] = near(16000, 384); m[1][1] = near(-16000, 384); m[2][2] = near(-15000, 1000);
        end
        2: begin
          m[0][0] = near(-16000, 384); m[1][1] = near(16000, 384); m[2][2] = near(-15000, 1000);
        end
        default: begin
          m[0][0] = near(-15000, 1000); m[1][1] = near(-16000, 384); m[2][2] = near(16000, 384);
        end
      endcase
      return m;
    end
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (quat_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic mat_t fill_mat(input elem_t d, input elem_t o);
    mat_t m;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) m[r][k] = (r == k) ? d : o;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    mat_t m;
    begin
      // Identity: positive trace.
      m = fill_mat(16384, 0); send_matrix(m);
      // Half turns about each axis: one per diagonal case.
      m = fill_mat(-16384, 0); m[0][0] = 16384; send_matrix(m);
      m = fill_mat(-16384, 0); m[1][1] = 16384; send_matrix(m);
      m = fill_mat(-16384, 0); m[2][2] = 16384; send_matrix(m);
      // Diagonal ties: equal elements keep the lower index.
      m = fill_mat(-8192, 100); send_matrix(m);
      m = fill_mat(0, 0); send_matrix(m);
      m = fill_mat(-16384, 0); m[1][1] = 4000; m[2][2] = 4000; send_matrix(m);
      // Most negative diagonal: the radicand stays positive, root nonzero.
      m = fill_mat(-32768, 32767); send_matrix(m);
      m = fill_mat(-32768, -32768); send_matrix(m);
      // Extremes: full-scale and most negative elements.
      m = fill_mat(32767, 32767); send_matrix(m);
      m = fill_mat(32767, -32768); send_matrix(m);
      m = fill_mat(1, -32768); m[2][1] = 32767; m[0][2] = 32767; m[1][0] = 32767;
      send_matrix(m);
      m = fill_mat(-32768, 0); m[0][0] = 32767; m[0][1] = 32767; m[1][0] = 32767;
      m[0][2] = -32768; m[2][0] = -32768; m[1][2] = 32767; m[2][1] = -32768;
      send_matrix(m);
      // Trace exactly zero takes the diagonal branch; trace one takes the other.
      m = fill_mat(0, 5000); m[0][0] = 1; m[1][1] = -1; send_matrix(m);
      m = fill_mat(0, 5000); m[0][0] = 1; send_matrix(m);
      // More diagonal-branch cases: the y axis, then every element at minus one.
      m = fill_mat(-16384, 3); m[0][0] = -16384; m[1][1] = 16384; m[2][2] = -16385;
      send_matrix(m);
      m = fill_mat(-1, -1); send_matrix(m);
    end
  endtask

  task automatic test_random_rotations(input int n);
    for (int i = 0; i < n; i++) send_matrix(rotation_like());
  endtask

  task automatic test_random_noise(input int n);
    mat_t m;
    for (int i = 0; i < n; i++) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) m[r][k] = rand_elem();
      send_matrix(m);
    end
  endtask

  // Back-to-back beats with both sides always ready.
  task automatic test_full_rate(input int n);
    quiet_stretch = 1'b1;
    test_random_rotations(n);
    wait_drained();
    quiet_stretch = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_rotations(300);
    wait_drained();        // sender holds off until every quaternion is back
    test_full_rate(120);
    test_random_noise(150);
    test_random_rotations(130);
    wait_drained();
    repeat (60) @(negedge clk_i);
    if (err_cnt == 0 && quat_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
